### rtl/core/xdwm_pkg.sv
// ----------------------------------------------------------------------------
// X-drive wheel mixer package
// Widths, payload types and register map shared by the mixer RTL.
// ----------------------------------------------------------------------------
package xdwm_pkg;

    // Speed field width (signed, 4 fraction bits).
    localparam int SPEED_W = 16;

    // Internal widths, all following from SPEED_W.
    localparam int SUM_W   = SPEED_W + 1;        // forward +/- sideways
    localparam int DIAG_W  = SPEED_W + 1;        // rotated component
    localparam int WHEEL_W = SPEED_W + 2;        // diagonal +/- turn
    localparam int MAG_W   = SPEED_W + 1;        // wheel magnitude

    // Speed limit register.
    localparam int LIM_W = 15;
    localparam logic [LIM_W-1:0] MAX_SPEED_RST = LIM_W'(9600);
    // Largest limit that still fits a wheel field.
    localparam logic [LIM_W-1:0] LIM_CAP = (SPEED_W - 1 >= LIM_W) ? {LIM_W{1'b1}} :
                                           LIM_W'((1 << (SPEED_W - 1)) - 1);

    // 0.70710678118 in Q0.15, round to nearest.
    localparam int COEF_W      = 15;
    localparam int COEF_SHIFT  = 15;
    localparam int PROD_DIAG_W = SUM_W + COEF_W;
    localparam logic [COEF_W-1:0] DIAG_COEF = COEF_W'(23170);
    localparam logic [PROD_DIAG_W-1:0] DIAG_ROUND = PROD_DIAG_W'(1) << (COEF_SHIFT - 1);

    // Scaling divider: one quotient bit per stage.
    localparam int PROD_W    = MAG_W + LIM_W;
    localparam int DIV_STEPS = LIM_W;
    localparam int NUM_WHEEL = 4;

    // Valid pipeline: four front stages, divider load plus steps, output.
    localparam int PIPE_LEN = 4 + DIV_STEPS + 1 + 1;

    // APB register map: index is paddr[2].
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED = REG_IDX_W'(0);

    // Command transaction.
    typedef struct packed {
        logic signed [SPEED_W-1:0] forward;
        logic signed [SPEED_W-1:0] sideways;
        logic signed [SPEED_W-1:0] turn;
    } t_cmd;

    // Result transaction.
    typedef struct packed {
        logic signed [SPEED_W-1:0] front_left;
        logic signed [SPEED_W-1:0] front_right;
        logic signed [SPEED_W-1:0] back_left;
        logic signed [SPEED_W-1:0] back_right;
        logic                      scaled;
    } t_wheels;

endpackage

### rtl/core/x_drive_wheel_mixer.sv
// ----------------------------------------------------------------------------
// X-drive wheel mixer
// Rotates the translation command by 45 degrees, mixes in turn, and scales all
// four wheels down by limit/largest when the largest magnitude is over limit.
//
//   channel   | handshake                        | payload
//   ----------+----------------------------------+---------------------------
//   command   | start in, busy out               | i_cmd    (xdwm_pkg::t_cmd)
//   result    | o_done out, one cycle per result | o_wheels (xdwm_pkg::t_wheels)
//   config    | APB psel/penable/pwrite, pready  | max_speed at paddr 0
//
// A command transaction is taken every cycle; busy stays low.
// The pipeline holds four mixing stages, the divider load stage, the scaling
// divider's 15 stages of one quotient bit each, and the output register.
// Reset (synchronous, active low) clears all stage valids and sets max_speed
// to 9600. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module x_drive_wheel_mixer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  xdwm_pkg::t_cmd                   i_cmd,
    // result channel
    output logic                             o_done,
    output xdwm_pkg::t_wheels                o_wheels,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [xdwm_pkg::PADDR_W-1:0]     paddr,
    input  logic [xdwm_pkg::PDATA_W-1:0]     pwdata,
    output logic [xdwm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    // Stage payload types.
    typedef struct packed {
        logic [xdwm_pkg::LIM_W-1:0]        lim;
        logic signed [xdwm_pkg::SUM_W-1:0] sum_a;
        logic signed [xdwm_pkg::SUM_W-1:0] sum_b;
        logic signed [xdwm_pkg::SPEED_W-1:0] turn;
    } t_s1;

    typedef struct packed {
        logic [xdwm_pkg::LIM_W-1:0]          lim;
        logic signed [xdwm_pkg::DIAG_W-1:0]  diag_a;
        logic signed [xdwm_pkg::DIAG_W-1:0]  diag_b;
        logic signed [xdwm_pkg::SPEED_W-1:0] turn;
    } t_s2;

    typedef struct packed {
        logic [xdwm_pkg::LIM_W-1:0]                                 lim;
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::WHEEL_W-1:0]       wheel;
    } t_s3;

    typedef struct packed {
        logic [xdwm_pkg::LIM_W-1:0]                                 lim;
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::SPEED_W-1:0]       wheel;
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::MAG_W-1:0]         mag;
        logic [xdwm_pkg::NUM_WHEEL-1:0]                             neg;
        logic [xdwm_pkg::MAG_W-1:0]                                 max01;
        logic [xdwm_pkg::MAG_W-1:0]                                 max23;
    } t_s4;

    typedef struct packed {
        logic                                                       scaled;
        logic [xdwm_pkg::MAG_W-1:0]                                 top;
        logic [xdwm_pkg::NUM_WHEEL-1:0]                             neg;
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::SPEED_W-1:0]       wheel;
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::MAG_W-1:0]         rem;
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::LIM_W-1:0]         nq;
    } t_div;

    // Multiply by 0.7071 on the magnitude, round half away from zero.
    function automatic logic signed [xdwm_pkg::DIAG_W-1:0] diag_mul(
        input logic signed [xdwm_pkg::SUM_W-1:0] x
    );
        logic [xdwm_pkg::SUM_W-1:0]       m;
        logic [xdwm_pkg::PROD_DIAG_W-1:0] p;
        logic [xdwm_pkg::DIAG_W-1:0]      r;
        m = x[xdwm_pkg::SUM_W-1] ? xdwm_pkg::SUM_W'(-x) : xdwm_pkg::SUM_W'(x);
        p = xdwm_pkg::PROD_DIAG_W'(m) * xdwm_pkg::PROD_DIAG_W'(xdwm_pkg::DIAG_COEF)
            + xdwm_pkg::DIAG_ROUND;
        r = p[xdwm_pkg::COEF_SHIFT +: xdwm_pkg::DIAG_W];
        return x[xdwm_pkg::SUM_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // Configuration and pipeline registers.
    logic [xdwm_pkg::LIM_W-1:0]     r_max_speed;
    logic [xdwm_pkg::PIPE_LEN-1:0]  r_vld;
    t_s1                            r_s1, n_s1;
    t_s2                            r_s2, n_s2;
    t_s3                            r_s3, n_s3;
    t_s4                            r_s4, n_s4;
    t_div                           r_div [0:xdwm_pkg::DIV_STEPS];
    t_div                           n_div [0:xdwm_pkg::DIV_STEPS];
    xdwm_pkg::t_wheels              r_out, n_out;
    logic                           cfg_wr;
    logic [xdwm_pkg::LIM_W-1:0]     lim_eff;

    // APB: single register, zero wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[2] == xdwm_pkg::REG_MAX_SPEED);
    assign prdata = (paddr[2] == xdwm_pkg::REG_MAX_SPEED) ?
                    xdwm_pkg::PDATA_W'(r_max_speed) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= xdwm_pkg::MAX_SPEED_RST;
        end else if (cfg_wr) begin
            r_max_speed <= pwdata[xdwm_pkg::LIM_W-1:0];
        end
    end

    // Never stall the command side.
    assign busy = 1'b0;

    // Advance valids every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[xdwm_pkg::PIPE_LEN-2:0], start};
        end
    end

    // Stage 1: diagonal sums, clamp limit to field range.
    assign lim_eff = (r_max_speed > xdwm_pkg::LIM_CAP) ? xdwm_pkg::LIM_CAP : r_max_speed;

    always_comb begin
        n_s1.lim   = lim_eff;
        n_s1.sum_a = xdwm_pkg::SUM_W'(i_cmd.sideways) + xdwm_pkg::SUM_W'(i_cmd.forward);
        n_s1.sum_b = xdwm_pkg::SUM_W'(i_cmd.forward) - xdwm_pkg::SUM_W'(i_cmd.sideways);
        n_s1.turn  = i_cmd.turn;
    end

    // Stage 2: rotate by 45 degrees.
    always_comb begin
        n_s2.lim    = r_s1.lim;
        n_s2.diag_a = diag_mul(r_s1.sum_a);
        n_s2.diag_b = diag_mul(r_s1.sum_b);
        n_s2.turn   = r_s1.turn;
    end

    // Stage 3: mix in turn.
    always_comb begin
        n_s3.lim      = r_s2.lim;
        n_s3.wheel[0] = xdwm_pkg::WHEEL_W'(r_s2.diag_a) + xdwm_pkg::WHEEL_W'(r_s2.turn);
        n_s3.wheel[1] = xdwm_pkg::WHEEL_W'(r_s2.diag_b) - xdwm_pkg::WHEEL_W'(r_s2.turn);
        n_s3.wheel[2] = xdwm_pkg::WHEEL_W'(r_s2.diag_b) + xdwm_pkg::WHEEL_W'(r_s2.turn);
        n_s3.wheel[3] = xdwm_pkg::WHEEL_W'(r_s2.diag_a) - xdwm_pkg::WHEEL_W'(r_s2.turn);
    end

    // Stage 4: magnitudes and pairwise maxima.
    always_comb begin
        n_s4.lim = r_s3.lim;
        for (int i = 0; i < xdwm_pkg::NUM_WHEEL; i++) begin
            n_s4.neg[i]   = r_s3.wheel[i][xdwm_pkg::WHEEL_W-1];
            n_s4.wheel[i] = r_s3.wheel[i][xdwm_pkg::SPEED_W-1:0];
            n_s4.mag[i]   = n_s4.neg[i] ? xdwm_pkg::MAG_W'(-r_s3.wheel[i]) :
                                          xdwm_pkg::MAG_W'(r_s3.wheel[i]);
        end
        n_s4.max01 = (n_s4.mag[0] > n_s4.mag[1]) ? n_s4.mag[0] : n_s4.mag[1];
        n_s4.max23 = (n_s4.mag[2] > n_s4.mag[3]) ? n_s4.mag[2] : n_s4.mag[3];
    end

    // Stage 5: largest magnitude, limit check, numerators for the divider.
    always_comb begin
        logic [xdwm_pkg::PROD_W-1:0] prod;
        n_div[0].top    = (r_s4.max01 > r_s4.max23) ? r_s4.max01 : r_s4.max23;
        n_div[0].scaled = n_div[0].top > xdwm_pkg::MAG_W'(r_s4.lim);
        n_div[0].neg    = r_s4.neg;
        n_div[0].wheel  = r_s4.wheel;
        for (int i = 0; i < xdwm_pkg::NUM_WHEEL; i++) begin
            prod = xdwm_pkg::PROD_W'(r_s4.mag[i]) * xdwm_pkg::PROD_W'(r_s4.lim);
            n_div[0].rem[i] = prod[xdwm_pkg::PROD_W-1 -: xdwm_pkg::MAG_W];
            n_div[0].nq[i]  = prod[xdwm_pkg::LIM_W-1:0];
        end
    end

    // Divider steps: shift in one numerator bit, subtract top if it fits.
    for (genvar k = 1; k <= xdwm_pkg::DIV_STEPS; k++) begin : g_div
        always_comb begin
            logic [xdwm_pkg::MAG_W:0] t;
            logic                     ge;
            n_div[k].scaled = r_div[k-1].scaled;
            n_div[k].top    = r_div[k-1].top;
            n_div[k].neg    = r_div[k-1].neg;
            n_div[k].wheel  = r_div[k-1].wheel;
            for (int i = 0; i < xdwm_pkg::NUM_WHEEL; i++) begin
                t  = {r_div[k-1].rem[i], r_div[k-1].nq[i][xdwm_pkg::LIM_W-1]};
                ge = t >= {1'b0, r_div[k-1].top};
                n_div[k].rem[i] = ge ? xdwm_pkg::MAG_W'(t - {1'b0, r_div[k-1].top}) :
                                       t[xdwm_pkg::MAG_W-1:0];
                n_div[k].nq[i]  = {r_div[k-1].nq[i][xdwm_pkg::LIM_W-2:0], ge};
            end
        end
    end

    // Output: signed quotient when scaled, else the mixed wheel.
    always_comb begin
        logic [xdwm_pkg::NUM_WHEEL-1:0][xdwm_pkg::SPEED_W-1:0] w;
        logic [xdwm_pkg::SPEED_W-1:0]                          q;
        for (int i = 0; i < xdwm_pkg::NUM_WHEEL; i++) begin
            q = xdwm_pkg::SPEED_W'(r_div[xdwm_pkg::DIV_STEPS].nq[i]);
            if (r_div[xdwm_pkg::DIV_STEPS].scaled) begin
                w[i] = r_div[xdwm_pkg::DIV_STEPS].neg[i] ? -q : q;
            end else begin
                w[i] = r_div[xdwm_pkg::DIV_STEPS].wheel[i];
            end
        end
        n_out.front_left  = w[0];
        n_out.front_right = w[1];
        n_out.back_left   = w[2];
        n_out.back_right  = w[3];
        n_out.scaled      = r_div[xdwm_pkg::DIV_STEPS].scaled;
    end

    // Payload registers: no reset, valids qualify them.
    always_ff @(posedge i_clk) begin
        r_s1  <= n_s1;
        r_s2  <= n_s2;
        r_s3  <= n_s3;
        r_s4  <= n_s4;
        r_out <= n_out;
        for (int k = 0; k <= xdwm_pkg::DIV_STEPS; k++) begin
            r_div[k] <= n_div[k];
        end
    end

    assign o_done   = r_vld[xdwm_pkg::PIPE_LEN-1];
    assign o_wheels = r_out;

endmodule
